[design/scpc_pkg.sv]
// ----------------------------------------------------------------------------
// scpc_pkg
// shared types, constants and the duty scaling function for the servo
// command and preset controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scpc_pkg;

    localparam int NUM_SLOTS  = 4;
    localparam int MAX_CHARS  = 9;
    localparam int SLOT_W     = $clog2(NUM_SLOTS + 1);
    localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int KEEP_W     = $clog2(MAX_CHARS + 1);
    localparam int DUTY_W     = 6;
    localparam int NUM_CHAN   = 4;

    // event kinds
    localparam logic [1:0] OP_SERIAL = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_SAVE   = 2'd2;

    // operating modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_MANUAL = 2'd1;
    localparam logic [1:0] MODE_PRESET = 2'd2;
    localparam logic [1:0] MODE_SERIAL = 2'd3;

    // parser characters
    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_1    = 8'h31;
    localparam logic [7:0] CH_3    = 8'h33;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_H    = 8'h48;
    localparam logic [7:0] CH_P    = 8'h50;

    typedef logic [DUTY_W-1:0] t_duty;

    typedef struct packed {
        logic              mode_wr;
        logic [1:0]        mode_val;
        logic              chan_wr;
        logic [1:0]        chan_idx;
        logic [7:0]        number;
        logic              slot_wr;
        logic [SLOT_W-1:0] slot_val;
    } t_parse_act;

    // v*30/255+7, the divide by 255 done as (p + p/256 + 1) / 256
    function automatic t_duty scale(input logic [7:0] v);
        logic [12:0] p;
        logic [13:0] q;
        p = {v, 5'b0} - {4'b0, v, 1'b0};
        q = ({1'b0, p} + {9'b0, p[12:8]} + 14'd1) >> 8;
        return DUTY_W'(q + 14'd7);
    endfunction

endpackage

[design/scpc_in_if.sv]
// ----------------------------------------------------------------------------
// scpc_in_if
// event channel: valid/ready handshake with opcode and value
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface scpc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

[design/scpc_out_if.sv]
// ----------------------------------------------------------------------------
// scpc_out_if
// result channel: valid/ready handshake with duties, mode and preset slot
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface scpc_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] duty_1a;
    logic [5:0] duty_1b;
    logic [5:0] duty_2a;
    logic [5:0] duty_2b;
    logic [1:0] mode;
    logic [2:0] preset_slot;

    modport source (output valid, output duty_1a, output duty_1b, output duty_2a,
                    output duty_2b, output mode, output preset_slot, input ready);
    modport sink   (input valid, input duty_1a, input duty_1b, input duty_2a,
                    input duty_2b, input mode, input preset_slot, output ready);
endinterface

[design/scpc_parser.sv]
// ----------------------------------------------------------------------------
// scpc_parser
// serial command parser: pending flags, number entry and the actions that
// one received byte causes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scpc_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_byte_valid,
    input  logic [7:0]            i_byte,
    output scpc_pkg::t_parse_act  o_act
);

    localparam int FLAG_MODE  = 0;
    localparam int FLAG_CHAN0 = 1;
    localparam int FLAG_SLOT  = 5;

    logic [5:0]                    r_flags,  n_flags;
    logic [7:0]                    r_number, n_number;
    logic [scpc_pkg::KEEP_W-1:0]   r_kept,   n_kept;
    logic                          r_ended,  n_ended;

    logic [1:0] chan;
    logic [7:0] slot_off;
    logic       is_digit;

    always_comb begin
        chan = 2'd0;
        for (int i = 3; i >= 0; i--) begin
            if (r_flags[FLAG_CHAN0 + i]) begin
                chan = 2'(i);
            end
        end
    end

    assign is_digit = (i_byte >= scpc_pkg::CH_0) && (i_byte <= scpc_pkg::CH_9);
    assign slot_off = i_byte - scpc_pkg::CH_1;

    always_comb begin
        o_act    = '0;
        n_flags  = r_flags;
        n_number = r_number;
        n_kept   = r_kept;
        n_ended  = r_ended;
        if (i_byte_valid) begin
            if (r_flags[FLAG_MODE]) begin
                if (i_byte >= scpc_pkg::CH_1 && i_byte <= scpc_pkg::CH_3) begin
                    o_act.mode_wr  = 1'b1;
                    o_act.mode_val = 2'(i_byte - scpc_pkg::CH_0);
                end
                n_flags[FLAG_MODE] = 1'b0;
            end else if (|r_flags[FLAG_CHAN0 +: 4]) begin
                if (i_byte == scpc_pkg::CH_H) begin
                    o_act.chan_wr  = 1'b1;
                    o_act.chan_idx = chan;
                    o_act.number   = r_number;
                    n_flags[FLAG_CHAN0 + 32'(chan)] = 1'b0;
                    n_number = 8'd0;
                    n_kept   = '0;
                    n_ended  = 1'b0;
                end else if (32'(r_kept) < scpc_pkg::MAX_CHARS) begin
                    n_kept = r_kept + scpc_pkg::KEEP_W'(1);
                    if (!r_ended) begin
                        if (is_digit) begin
                            n_number = {r_number[4:0], 3'b0} + {r_number[6:0], 1'b0}
                                       + (i_byte - scpc_pkg::CH_0);
                        end else begin
                            n_ended = 1'b1;
                        end
                    end
                end
            end else if (r_flags[FLAG_SLOT]) begin
                if (i_byte >= scpc_pkg::CH_1 && 32'(slot_off) < scpc_pkg::NUM_SLOTS) begin
                    o_act.slot_wr  = 1'b1;
                    o_act.slot_val = scpc_pkg::SLOT_W'(i_byte - scpc_pkg::CH_0);
                end
                n_flags[FLAG_SLOT] = 1'b0;
            end

            if (i_byte == scpc_pkg::CH_DOT) begin
                n_flags[FLAG_MODE] = 1'b1;
            end else if (i_byte >= scpc_pkg::CH_A && i_byte <= scpc_pkg::CH_D) begin
                n_flags[FLAG_CHAN0 + 32'(2'(i_byte - scpc_pkg::CH_A))] = 1'b1;
                n_number = 8'd0;
                n_kept   = '0;
                n_ended  = 1'b0;
            end else if (i_byte == scpc_pkg::CH_P) begin
                n_flags[FLAG_SLOT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags  <= '0;
            r_number <= '0;
            r_kept   <= '0;
            r_ended  <= 1'b0;
        end else begin
            r_flags  <= n_flags;
            r_number <= n_number;
            r_kept   <= n_kept;
            r_ended  <= n_ended;
        end
    end

endmodule

[design/servo_command_and_preset_controller_top.sv]
// ----------------------------------------------------------------------------
// servo_command_and_preset_controller_top
// four servo duties driven by samples, serial commands and preset slots
// ----------------------------------------------------------------------------
//  channel  direction  fields
//  i_in     sink       opcode[1:0], value[7:0]
//  o_out    source     duty_1a/1b/2a/2b[5:0], mode[1:0], preset_slot[2:0]
//
//  one event per cycle unless o_out stalls: the state registers update on the
//  accepting edge and are themselves the result payload, shown the cycle after
//  a result waiting on o_out.ready holds i_in.ready low; taking it frees the
//  input in the same cycle
//  synchronous reset clears duties, mode, slot, parser and preset store at once
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module servo_command_and_preset_controller_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    scpc_in_if.sink          i_in,
    scpc_out_if.source       o_out
);

    scpc_pkg::t_duty               r_duty  [scpc_pkg::NUM_CHAN];
    scpc_pkg::t_duty               n_duty  [scpc_pkg::NUM_CHAN];
    scpc_pkg::t_duty               r_store [scpc_pkg::NUM_SLOTS][scpc_pkg::NUM_CHAN];
    scpc_pkg::t_duty               n_store [scpc_pkg::NUM_SLOTS][scpc_pkg::NUM_CHAN];
    logic [1:0]                    r_mode, n_mode;
    logic [1:0]                    r_chan, n_chan;
    logic [scpc_pkg::SLOT_W-1:0]   r_slot, n_slot;
    logic                          r_out_valid;

    logic                          accept;
    scpc_pkg::t_parse_act          act;

    function automatic logic slot_ok(input logic [scpc_pkg::SLOT_W-1:0] s);
        return (s != '0) && (32'(s) <= scpc_pkg::NUM_SLOTS);
    endfunction

    function automatic logic [scpc_pkg::SLOT_IDX_W-1:0] slot_idx(
        input logic [scpc_pkg::SLOT_W-1:0] s);
        logic [scpc_pkg::SLOT_W-1:0] d;
        d = s - scpc_pkg::SLOT_W'(1);
        return scpc_pkg::SLOT_IDX_W'(d);
    endfunction

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    scpc_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (accept && (i_in.opcode == scpc_pkg::OP_SERIAL)),
        .i_byte       (i_in.value),
        .o_act        (act)
    );

    always_comb begin
        n_duty  = r_duty;
        n_store = r_store;
        n_mode  = r_mode;
        n_chan  = r_chan;
        n_slot  = r_slot;
        if (accept) begin
            case (i_in.opcode)
                scpc_pkg::OP_SERIAL: begin
                    if (act.mode_wr) begin
                        n_mode = act.mode_val;
                    end
                    if (act.chan_wr && r_mode == scpc_pkg::MODE_SERIAL) begin
                        n_duty[act.chan_idx] = scpc_pkg::scale(act.number);
                    end
                    if (act.slot_wr) begin
                        n_slot = act.slot_val;
                    end
                end
                scpc_pkg::OP_SAMPLE: begin
                    // rotation 2B, 1A, 1B, 2A
                    if (r_mode == scpc_pkg::MODE_MANUAL) begin
                        n_duty[r_chan - 2'd1] = scpc_pkg::scale(i_in.value);
                    end
                    n_chan = r_chan + 2'd1;
                end
                scpc_pkg::OP_SAVE: begin
                    if (slot_ok(r_slot)) begin
                        n_store[slot_idx(r_slot)] = r_duty;
                    end
                end
                default: begin
                end
            endcase
            if (n_mode == scpc_pkg::MODE_PRESET && slot_ok(n_slot)) begin
                n_duty = n_store[slot_idx(n_slot)];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty      <= '{default: '0};
            r_store     <= '{default: '{default: '0}};
            r_mode      <= scpc_pkg::MODE_IDLE;
            r_chan      <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_duty  <= n_duty;
            r_store <= n_store;
            r_mode  <= n_mode;
            r_chan  <= n_chan;
            r_slot  <= n_slot;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.duty_1a     = r_duty[0];
    assign o_out.duty_1b     = r_duty[1];
    assign o_out.duty_2a     = r_duty[2];
    assign o_out.duty_2b     = r_duty[3];
    assign o_out.mode        = r_mode;
    assign o_out.preset_slot = 3'(r_slot);

endmodule
